FILE: design/cc20_pkg.sv
// shared types, constants and state encodings for the chacha20 stream cipher unit
package cc20_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] block_t;

	localparam word_t SIGMA0 = 32'h61707865;
	localparam word_t SIGMA1 = 32'h3320646e;
	localparam word_t SIGMA2 = 32'h79622d32;
	localparam word_t SIGMA3 = 32'h6b206574;

	localparam logic [6:0] BLOCK_BYTES = 7'd64;

	// last half round of ten double rounds
	localparam logic [4:0] LAST_HALF = 5'd19;

	typedef enum logic [2:0] {
		CFG_KEY_01   = 3'd0,
		CFG_KEY_23   = 3'd1,
		CFG_KEY_45   = 3'd2,
		CFG_KEY_67   = 3'd3,
		CFG_NONCE_01 = 3'd4,
		CFG_NONCE_2  = 3'd5,
		CFG_COUNTER  = 3'd6
	} cfg_index_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ROUND,
		CS_FINAL
	} core_state_t;

	typedef enum logic [1:0] {
		ST_READY,
		ST_GEN,
		ST_EMIT
	} state_t;

endpackage

FILE: design/chacha20_stream_cipher_unit.sv
// chacha20 stream cipher top level: configuration, keystream buffer and byte xor
// result: registered on the input transaction while keystream bytes remain; when a
// new block is needed the byte is parked through load, 80 round steps, feed-forward, emit
// input: no byte is taken while a block is made, so the byte rate is set by the 80
// single-step passes of the four-lane quarter-round unit in cc20_core
// reset: asynchronous, clears configuration registers, state, counter and fill so the first byte makes a block
module chacha20_stream_cipher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  result_byte,
	output logic        last_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import cc20_pkg::*;

	// configuration registers
	logic [7:0][31:0] key_q;
	logic [2:0][31:0] nonce_q;
	word_t            init_ctr_q;

	// keystream bookkeeping
	word_t      ctr_q;
	logic [6:0] left_q;

	state_t state_q, state_d;

	// output register and the byte parked while a block is made
	logic       out_valid_q;
	logic [7:0] result_q;
	logic       last_q;
	logic [7:0] hold_data_q;
	logic       hold_eom_q;

	logic       in_acc;
	logic       cfg_acc;
	logic       out_free;
	logic       left_zero;
	logic       core_start;
	logic       core_done;
	logic       emit;
	block_t     init_blk;
	block_t     ks_blk;
	logic [5:0] pos;
	word_t      ks_word;
	logic [7:0] ks_byte;
	logic [7:0] src_data;
	logic       src_eom;

	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign left_zero = (left_q == 7'd0);

	// block input: constants, key, counter, nonce
	always_comb begin
		init_blk[0]  = SIGMA0;
		init_blk[1]  = SIGMA1;
		init_blk[2]  = SIGMA2;
		init_blk[3]  = SIGMA3;
		for (int i = 0; i < 8; i++) init_blk[4 + i] = key_q[i];
		init_blk[12] = ctr_q;
		init_blk[13] = nonce_q[0];
		init_blk[14] = nonce_q[1];
		init_blk[15] = nonce_q[2];
	end

	cc20_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.init   (init_blk),
		.done   (core_done),
		.ks     (ks_blk)
	);

	// next keystream byte, little-endian within each word
	assign pos     = 6'(BLOCK_BYTES - left_q);
	assign ks_word = ks_blk[pos[5:2]];
	assign ks_byte = ks_word[{pos[1:0], 3'b000} +: 8];

	// fresh byte when buffered keystream is left, parked byte after a new block
	assign src_data = (state_q == ST_EMIT) ? hold_data_q : data_byte;
	assign src_eom  = (state_q == ST_EMIT) ? hold_eom_q : end_of_message;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_READY: if (in_acc && left_zero) state_d = ST_GEN;
			ST_GEN:   if (core_done) state_d = ST_EMIT;
			ST_EMIT:  if (out_free) state_d = ST_READY;
			default:  state_d = ST_READY;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == ST_READY) && out_free;
		cfg_ready  = (state_q == ST_READY);
		core_start = (state_q == ST_READY) && in_acc && left_zero;
		emit       = ((state_q == ST_READY) && in_acc && !left_zero) ||
		             ((state_q == ST_EMIT) && out_free);
	end

	assign out_valid   = out_valid_q;
	assign result_byte = result_q;
	assign last_byte   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_READY;
			key_q       <= '0;
			nonce_q     <= '0;
			init_ctr_q  <= '0;
			ctr_q       <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			if (core_done) begin
				left_q <= BLOCK_BYTES;
				ctr_q  <= ctr_q + 32'd1;
			end else if (emit) begin
				left_q <= left_q - 7'd1;
			end

			// any known register write reloads the counter and drops the buffer
			if (cfg_acc) begin
				unique case (cfg_index)
					CFG_KEY_01: begin
						key_q[0] <= cfg_data[31:0];
						key_q[1] <= cfg_data[63:32];
					end
					CFG_KEY_23: begin
						key_q[2] <= cfg_data[31:0];
						key_q[3] <= cfg_data[63:32];
					end
					CFG_KEY_45: begin
						key_q[4] <= cfg_data[31:0];
						key_q[5] <= cfg_data[63:32];
					end
					CFG_KEY_67: begin
						key_q[6] <= cfg_data[31:0];
						key_q[7] <= cfg_data[63:32];
					end
					CFG_NONCE_01: begin
						nonce_q[0] <= cfg_data[31:0];
						nonce_q[1] <= cfg_data[63:32];
					end
					CFG_NONCE_2: nonce_q[2] <= cfg_data[31:0];
					CFG_COUNTER: init_ctr_q <= cfg_data[31:0];
					default: ;
				endcase
				if (cfg_index <= CFG_COUNTER) begin
					left_q <= '0;
					ctr_q  <= (cfg_index == CFG_COUNTER) ? cfg_data[31:0] : init_ctr_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (core_start) begin
			hold_data_q <= data_byte;
			hold_eom_q  <= end_of_message;
		end
		if (emit) begin
			result_q <= src_data ^ ks_byte;
			last_q   <= src_eom;
		end
	end

endmodule

FILE: design/cc20_core.sv
// iterative chacha20 block core: four quarter-round lanes, one step per cycle
module cc20_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  cc20_pkg::block_t init,
	output logic            done,
	output cc20_pkg::block_t ks
);
	import cc20_pkg::*;

	core_state_t state_q, state_d;
	logic [4:0]  half_q;
	logic [1:0]  step_q;
	block_t      x_q;
	block_t      lane_d;
	block_t      perm_d;
	logic        last_step;
	logic        last_half;

	function automatic word_t rotl(input word_t v, input logic [1:0] s);
		word_t r;
		unique case (s)
			2'd0: r = {v[15:0], v[31:16]};
			2'd1: r = {v[19:0], v[31:20]};
			2'd2: r = {v[23:0], v[31:24]};
			2'd3: r = {v[24:0], v[31:25]};
			default: r = v;
		endcase
		return r;
	endfunction

	assign last_step = (step_q == 2'd3);
	assign last_half = (half_q == LAST_HALF);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE:  if (start) state_d = CS_ROUND;
			CS_ROUND: if (last_step && last_half) state_d = CS_FINAL;
			CS_FINAL: state_d = CS_IDLE;
			default:  state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == CS_FINAL);
		ks   = x_q;
	end

	// one add-xor-rotate step in each column lane
	always_comb begin
		word_t p, q, r, sum, mix;
		lane_d = x_q;
		for (int l = 0; l < 4; l++) begin
			if (!step_q[0]) begin
				p = x_q[l];
				q = x_q[4 + l];
				r = x_q[12 + l];
			end else begin
				p = x_q[8 + l];
				q = x_q[12 + l];
				r = x_q[4 + l];
			end
			sum = p + q;
			mix = rotl(r ^ sum, step_q);
			if (!step_q[0]) begin
				lane_d[l]      = sum;
				lane_d[12 + l] = mix;
			end else begin
				lane_d[8 + l]  = sum;
				lane_d[4 + l]  = mix;
			end
		end
	end

	// rows shift into diagonal order after a column round and back after a diagonal round
	always_comb begin
		perm_d = lane_d;
		if (last_step) begin
			for (int l = 0; l < 4; l++) begin
				if (!half_q[0]) begin
					perm_d[4 + l]  = lane_d[4 + ((l + 1) & 3)];
					perm_d[8 + l]  = lane_d[8 + ((l + 2) & 3)];
					perm_d[12 + l] = lane_d[12 + ((l + 3) & 3)];
				end else begin
					perm_d[4 + l]  = lane_d[4 + ((l + 3) & 3)];
					perm_d[8 + l]  = lane_d[8 + ((l + 2) & 3)];
					perm_d[12 + l] = lane_d[12 + ((l + 1) & 3)];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			half_q  <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == CS_IDLE && start) begin
				half_q <= '0;
				step_q <= '0;
			end else if (state_q == CS_ROUND) begin
				step_q <= step_q + 2'd1;
				if (last_step) half_q <= half_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CS_IDLE && start) begin
			x_q <= init;
		end else if (state_q == CS_ROUND) begin
			x_q <= perm_d;
		end else if (state_q == CS_FINAL) begin
			for (int i = 0; i < 16; i++) x_q[i] <= x_q[i] + init[i];
		end
	end

endmodule

FILE: tb/chacha20_stream_cipher_unit_tb.sv
// self-checking testbench for the chacha20 stream cipher unit: byte stream and register writes
module chacha20_stream_cipher_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cc20_pkg::*;

	// run length and safety limits
	localparam int unsigned RANDOM_BYTES  = 1930;
	localparam int unsigned SETTLE_CYCLES = 100;   // lets the core go idle after the last result
	localparam int unsigned CYCLE_LIMIT   = 500000;

	// write index outside the register map, must be ignored
	localparam logic [2:0] CFG_UNUSED = 3'd7;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} plain_t;

	typedef struct {
		logic [7:0] ct;
		logic       last;
	} cipher_t;

	// dut ports, all inputs driven to known values from time zero
	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte      = '0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [7:0]  result_byte;
	logic        last_byte;
	logic        cfg_valid      = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index      = '0;
	logic [63:0] cfg_data       = '0;

	// bytes waiting for the driver, and cipher bytes waiting for the dut
	plain_t  plain_q[$];
	cipher_t cipher_q[$];

	// idle percentages for the two channels
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	// keystream generator state, mirrors the cipher
	logic [7:0][31:0] key_w   = '0;
	logic [2:0][31:0] nonce_w = '0;
	word_t            ctr_load = '0;
	word_t            ctr      = '0;
	block_t           ks_words = '0;
	int unsigned      ks_left  = 0;

	// bookkeeping
	int unsigned n_cycles = 0;
	int unsigned n_err    = 0;
	int unsigned n_in     = 0;
	int unsigned n_out    = 0;
	int unsigned n_writes = 0;
	int unsigned n_blocks = 0;
	int unsigned n_phases = 0;

	logic [7:0] drv_ks;
	cipher_t    drv_exp;
	cipher_t    mon_exp;

	cfg_index_t all_regs[7] = '{CFG_KEY_01, CFG_KEY_23, CFG_KEY_45, CFG_KEY_67,
		CFG_NONCE_01, CFG_NONCE_2, CFG_COUNTER};

	chacha20_stream_cipher_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_byte    (result_byte),
		.last_byte      (last_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// keystream generation
	// ---------------------------------------------------------------

	function automatic word_t rotl32(word_t v, int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic block_t quarter(block_t x, int a, int b, int c, int d);
		x[a] = x[a] + x[b]; x[d] = rotl32(x[d] ^ x[a], 16);
		x[c] = x[c] + x[d]; x[b] = rotl32(x[b] ^ x[c], 12);
		x[a] = x[a] + x[b]; x[d] = rotl32(x[d] ^ x[a], 8);
		x[c] = x[c] + x[d]; x[b] = rotl32(x[b] ^ x[c], 7);
		return x;
	endfunction

	// 20 rounds plus feed-forward, then bump the block counter (wraps at 2^32)
	function automatic void make_keystream_block();
		block_t seed_w;
		block_t x;
		seed_w[0] = SIGMA0;
		seed_w[1] = SIGMA1;
		seed_w[2] = SIGMA2;
		seed_w[3] = SIGMA3;
		for (int t = 0; t < 8; t++)
			seed_w[4 + t] = key_w[t];
		seed_w[12] = ctr;
		seed_w[13] = nonce_w[0];
		seed_w[14] = nonce_w[1];
		seed_w[15] = nonce_w[2];
		x = seed_w;
		for (int r = 0; r < 10; r++) begin
			// column round
			x = quarter(x, 0, 4, 8, 12);
			x = quarter(x, 1, 5, 9, 13);
			x = quarter(x, 2, 6, 10, 14);
			x = quarter(x, 3, 7, 11, 15);
			// diagonal round
			x = quarter(x, 0, 5, 10, 15);
			x = quarter(x, 1, 6, 11, 12);
			x = quarter(x, 2, 7, 8, 13);
			x = quarter(x, 3, 4, 9, 14);
		end
		for (int t = 0; t < 16; t++)
			ks_words[t] = x[t] + seed_w[t];
		ctr = ctr + 32'd1;
		ks_left = BLOCK_BYTES;
		n_blocks++;
	endfunction

	// bytes come out little-endian within each word, word 0 first
	function automatic logic [7:0] next_keystream_byte();
		int unsigned pos;
		word_t       w;
		if (ks_left == 0)
			make_keystream_block();
		pos = BLOCK_BYTES - ks_left;
		w = ks_words[pos >> 2];
		ks_left--;
		return w[8 * (pos % 4) +: 8];
	endfunction

	// any known register write reloads the counter and drops the buffered keystream
	function automatic void apply_reg_write(logic [2:0] idx, logic [63:0] val);
		bit known;
		known = 1'b1;
		case (idx)
			CFG_KEY_01: begin
				key_w[0] = val[31:0];
				key_w[1] = val[63:32];
			end
			CFG_KEY_23: begin
				key_w[2] = val[31:0];
				key_w[3] = val[63:32];
			end
			CFG_KEY_45: begin
				key_w[4] = val[31:0];
				key_w[5] = val[63:32];
			end
			CFG_KEY_67: begin
				key_w[6] = val[31:0];
				key_w[7] = val[63:32];
			end
			CFG_NONCE_01: begin
				nonce_w[0] = val[31:0];
				nonce_w[1] = val[63:32];
			end
			CFG_NONCE_2: nonce_w[2] = val[31:0];
			CFG_COUNTER: ctr_load = val[31:0];
			default: known = 1'b0;
		endcase
		if (known) begin
			ctr = ctr_load;
			ks_left = 0;
		end
	endfunction

	// ---------------------------------------------------------------
	// input driver: takes bytes from plain_q, predicts on each transaction
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				drv_ks = next_keystream_byte();
				drv_exp.ct = data_byte ^ drv_ks;
				drv_exp.last = end_of_message;
				cipher_q.push_back(drv_exp);
				n_in++;
			end
			// slot is free when nothing is offered or the offer was just taken
			if (!in_valid || in_ready) begin
				if (plain_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					data_byte <= plain_q[0].data;
					end_of_message <= plain_q[0].last;
					plain_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// output monitor: random back-pressure, compare against oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (cipher_q.size() == 0) begin
					$error("unexpected transaction: result_byte %02h last_byte %0b",
						result_byte, last_byte);
					n_err++;
				end else begin
					mon_exp = cipher_q.pop_front();
					if (result_byte !== mon_exp.ct) begin
						$error("result_byte: expected %02h, actual %02h", mon_exp.ct, result_byte);
						n_err++;
					end
					if (last_byte !== mon_exp.last) begin
						$error("last_byte: expected %0b, actual %0b", mon_exp.last, last_byte);
						n_err++;
					end
					n_out++;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				n_cycles, cipher_q.size());
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// sequencing helpers
	// ---------------------------------------------------------------

	// wait until every byte is in and every result is out, then let the core settle;
	// returns on a rising edge so register writes can start right away
	task automatic wait_drained();
		do @(negedge clk);
		while (plain_q.size() != 0 || in_valid || cipher_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// entered on a rising edge; leaves cfg_valid high so writes can go back to back
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		apply_reg_write(idx, val);
		n_writes++;
	endtask

	function automatic void push_byte(logic [7:0] data, logic last);
		plain_t p;
		p.data = data;
		p.last = last;
		plain_q.push_back(p);
	endfunction

	// split len bytes into messages of random length, flag on each last byte
	function automatic void queue_messages(int unsigned len);
		int unsigned left;
		int unsigned msg;
		left = len;
		while (left > 0) begin
			msg = $urandom_range(100, 1);
			if (msg > left)
				msg = left;
			for (int unsigned i = 0; i < msg; i++)
				push_byte(8'($urandom_range(255)), i == msg - 1);
			left -= msg;
		end
	endfunction

	function automatic logic [63:0] pick_reg_value(cfg_index_t r);
		logic [63:0] v;
		case ($urandom_range(7))
			0: v = '0;
			1: v = '1;
			default: v = {$urandom, $urandom};
		endcase
		// counter often placed just below the wrap point
		if (r == CFG_COUNTER && $urandom_range(3) == 0)
			v[31:0] = 32'hFFFF_FFFF - $urandom_range(1);
		return v;
	endfunction

	// random subset of registers; the wrap phase writes all and parks the counter at 2^32-2
	task automatic random_config(input bit wrap_phase);
		logic [63:0] v;
		foreach (all_regs[i]) begin
			if (wrap_phase || $urandom_range(4) < 2) begin
				v = pick_reg_value(all_regs[i]);
				if (wrap_phase && all_regs[i] == CFG_COUNTER)
					v[31:0] = 32'hFFFF_FFFE;
				write_reg(all_regs[i], v);
			end
		end
		if ($urandom_range(9) == 0)
			write_reg(CFG_UNUSED, {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	initial begin
		int unsigned rnd_total;
		int unsigned len;
		rnd_total = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed part runs with the sender mostly busy and the receiver stalling a lot
		send_idle_pct = 6;
		recv_idle_pct = 60;

		// defaults after reset: zero key, nonce and counter; byte extremes
		@(negedge clk);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(8'h80, 1'b1);
		n_phases++;
		wait_drained();

		// every register at all ones, counter one step from wrapping
		foreach (all_regs[i])
			write_reg(all_regs[i], '1);
		cfg_valid <= 1'b0;
		@(negedge clk);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'h00, 1'b1);
		n_phases++;
		wait_drained();

		// write to an unmapped index: keystream must carry on mid-block
		write_reg(CFG_UNUSED, {$urandom, $urandom});
		cfg_valid <= 1'b0;
		@(negedge clk);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h0F, 1'b0);
		push_byte(8'hF0, 1'b1);
		wait_drained();

		// sequential key bytes, counter 1, nonce word 1 = 0x4a000000
		write_reg(CFG_KEY_01,   64'h07060504_03020100);
		write_reg(CFG_KEY_23,   64'h0f0e0d0c_0b0a0908);
		write_reg(CFG_KEY_45,   64'h17161514_13121110);
		write_reg(CFG_KEY_67,   64'h1f1e1d1c_1b1a1918);
		write_reg(CFG_NONCE_01, 64'h4a000000_00000000);
		write_reg(CFG_NONCE_2,  64'h0);
		write_reg(CFG_COUNTER,  64'h1);
		cfg_valid <= 1'b0;
		@(negedge clk);
		push_byte(8'h4c, 1'b0);
		push_byte(8'h61, 1'b0);
		push_byte(8'h64, 1'b0);
		push_byte(8'h69, 1'b1);
		n_phases++;
		wait_drained();

		// a single nonce write restarts from a fresh block with the counter reloaded
		write_reg(CFG_NONCE_2, {$urandom, $urandom});
		cfg_valid <= 1'b0;
		@(negedge clk);
		push_byte(8'h3C, 1'b0);
		push_byte(8'hC3, 1'b0);
		push_byte(8'h7E, 1'b1);
		n_phases++;

		// random phases: new settings, then a run of messages;
		// idling moves from receiver-heavy to sender-heavy to none
		while (rnd_total < RANDOM_BYTES) begin
			wait_drained();
			random_config(rnd_total == 0);
			@(negedge clk);
			if (rnd_total < RANDOM_BYTES / 3) begin
				send_idle_pct = 6;
				recv_idle_pct = 60;
			end else if (rnd_total < 2 * RANDOM_BYTES / 3) begin
				send_idle_pct = 60;
				recv_idle_pct = 6;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// first random phase crosses the counter wrap over several blocks
			len = (rnd_total == 0) ? 200 : $urandom_range(250, 40);
			queue_messages(len);
			rnd_total += len;
			n_phases++;
		end

		wait_drained();

		$display("covered %0d bytes in %0d phases, %0d register writes, %0d keystream blocks",
			n_out, n_phases, n_writes, n_blocks);
		$display("included counter wrap, ignored index, restarts mid-block, %0d mismatches",
			n_err);
		if (n_err == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
